// ===== rtl/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch packet deframer package
// Frame states, sync bytes and the report record shared by the deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'h54;

  localparam logic [3:0] POS_STATUS = 4'd2;
  localparam logic [3:0] POS_X_LO   = 4'd3;
  localparam logic [3:0] POS_X_HI   = 4'd4;
  localparam logic [3:0] POS_Y_LO   = 4'd5;
  localparam logic [3:0] POS_Y_HI   = 4'd6;

  localparam logic [3:0] CNT_AFTER_FIRST  = 4'd1;
  localparam logic [3:0] CNT_AFTER_SECOND = 4'd2;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_SECOND  = 2'd1,
    ST_COLLECT = 2'd2
  } frame_state_t;

  typedef struct packed {
    logic        done;
    logic        touch_active;
    logic [2:0]  status_bits;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
  } report_t;

endpackage

// ===== rtl/tpd_framer.sv =====
// ----------------------------------------------------------------------------
// Touch packet framer
// Sync hunt, byte position tracking and capture of status, X and Y fields.
// ----------------------------------------------------------------------------
module tpd_framer #(
  parameter int PACKET_LENGTH = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            beat_en,
  input  logic [7:0]      rx_byte,
  output tpd_pkg::report_t report
);

  tpd_pkg::frame_state_t state_r, state_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [3:0]  count_inc;
  logic        last_byte;
  logic [2:0]  held_status_r, held_status_nxt;
  logic [15:0] held_x_r, held_x_nxt;
  logic [15:0] held_y_r, held_y_nxt;

  assign count_inc = count_r + 4'd1;
  assign last_byte = (count_inc >= 4'(PACKET_LENGTH)) || (count_inc == 4'd0);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      tpd_pkg::ST_SECOND: begin
        if (rx_byte == tpd_pkg::SYNC_SECOND) begin
          state_nxt = tpd_pkg::ST_COLLECT;
          count_nxt = tpd_pkg::CNT_AFTER_SECOND;
        end else if (rx_byte == tpd_pkg::SYNC_FIRST) begin
          count_nxt = tpd_pkg::CNT_AFTER_FIRST;
        end else begin
          state_nxt = tpd_pkg::ST_HUNT;
          count_nxt = 4'd0;
        end
      end
      tpd_pkg::ST_COLLECT: begin
        if (last_byte) begin
          state_nxt = tpd_pkg::ST_HUNT;
          count_nxt = 4'd0;
        end else begin
          count_nxt = count_inc;
        end
      end
      default: begin
        if (rx_byte == tpd_pkg::SYNC_FIRST) begin
          state_nxt = tpd_pkg::ST_SECOND;
          count_nxt = tpd_pkg::CNT_AFTER_FIRST;
        end else begin
          state_nxt = tpd_pkg::ST_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    held_status_nxt = held_status_r;
    held_x_nxt      = held_x_r;
    held_y_nxt      = held_y_r;
    if (state_r == tpd_pkg::ST_COLLECT) begin
      case (count_r)
        tpd_pkg::POS_STATUS: held_status_nxt = rx_byte[2:0];
        tpd_pkg::POS_X_LO:   held_x_nxt      = {held_x_r[15:8], rx_byte};
        tpd_pkg::POS_X_HI:   held_x_nxt      = {rx_byte, held_x_r[7:0]};
        tpd_pkg::POS_Y_LO:   held_y_nxt      = {held_y_r[15:8], rx_byte};
        tpd_pkg::POS_Y_HI:   held_y_nxt      = {rx_byte, held_y_r[7:0]};
        default: ;
      endcase
    end
    report.done         = beat_en && (state_r == tpd_pkg::ST_COLLECT) && last_byte;
    report.touch_active = |held_status_nxt[1:0];
    report.status_bits  = held_status_nxt;
    report.x_coord      = held_x_nxt;
    report.y_coord      = held_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpd_pkg::ST_HUNT;
      count_r <= 4'd0;
    end else if (beat_en) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_en) begin
      held_status_r <= held_status_nxt;
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
    end
  end

  a_done_in_collect: assert property (@(posedge clk) disable iff (!rst_n)
    report.done |-> state_r == tpd_pkg::ST_COLLECT)
    else $error("report outside collect state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpd_pkg::ST_COLLECT |->
      (count_r >= tpd_pkg::CNT_AFTER_SECOND) && (count_r < 4'(PACKET_LENGTH)))
    else $error("byte position out of packet range");

  a_sync_seen: assert property (@(posedge clk) disable iff (!rst_n)
    beat_en && state_r == tpd_pkg::ST_HUNT && rx_byte == tpd_pkg::SYNC_FIRST |=>
      state_r == tpd_pkg::ST_SECOND && count_r == tpd_pkg::CNT_AFTER_FIRST)
    else $error("first sync byte not taken");

  a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
    report.done |=> state_r == tpd_pkg::ST_HUNT && count_r == 4'd0)
    else $error("framer did not rearm after report");

endmodule

// ===== rtl/touch_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// Touch packet deframer
// Takes one serial byte per input beat, finds the two-byte sync, collects a
// PACKET_LENGTH-byte packet and emits one touch report per packet.
//
// Input channel: in_valid, in_stall, in_rx_byte. One byte per beat.
// Result channel: out_valid, out_stall and the report fields.
// A byte is taken in every cycle while the result register is free or being
// drained in that cycle, so throughput is one byte per cycle.
// The report for a packet is registered and appears in the cycle after its last byte is taken.
// Bytes that end no packet produce no result beat.
// in_stall rises only while a report waits and out_stall is high; the report
// holds until taken.
// Reset clears the sync hunt, byte position and result valid; the captured
// status and coordinates are only meaningful once a packet fills them.
// ----------------------------------------------------------------------------
module touch_packet_deframer #(
  parameter int PACKET_LENGTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_touch_active,
  output logic [2:0]  out_status_bits,
  output logic [15:0] out_x_coord,
  output logic [15:0] out_y_coord
);

  logic             beat_en;
  tpd_pkg::report_t report;
  logic             out_valid_r, out_valid_nxt;
  logic             touch_active_r;
  logic [2:0]       status_bits_r;
  logic [15:0]      x_coord_r;
  logic [15:0]      y_coord_r;

  assign in_stall = out_valid_r && out_stall;
  assign beat_en  = in_valid && !in_stall;

  tpd_framer #(
    .PACKET_LENGTH(PACKET_LENGTH)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (beat_en),
    .rx_byte (in_rx_byte),
    .report  (report)
  );

  always_comb begin
    out_valid_nxt = (out_valid_r && out_stall) || report.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (report.done) begin
      touch_active_r <= report.touch_active;
      status_bits_r  <= report.status_bits;
      x_coord_r      <= report.x_coord;
      y_coord_r      <= report.y_coord;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_touch_active = touch_active_r;
  assign out_status_bits  = status_bits_r;
  assign out_x_coord      = x_coord_r;
  assign out_y_coord      = y_coord_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !report.done)
    else $error("report produced while result register is blocked");

  a_report_loads: assert property (@(posedge clk) disable iff (!rst_n)
    report.done |=> out_valid_r && out_status_bits == $past(report.status_bits))
    else $error("report not captured");

  a_active_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_touch_active == (|out_status_bits[1:0]))
    else $error("touch flag disagrees with status");

endmodule
